// ===== hw/rtl/mbp_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mbp_pkg
// Shared types, constants and helpers for the MSB-first bit packer.
// ----------------------------------------------------------------------------
package mbp_pkg;

	localparam int POS_W     = 20;  // bit position width
	localparam int VAL_W     = 32;  // field value width
	localparam int CNT_W     = 6;   // bit count / align multiple width
	localparam int WIN_W     = 40;  // current byte plus up to 32 new bits
	localparam int ADDR_W    = 16;  // reported byte address width
	localparam int NB_W      = 3;   // bytes touched per request, up to 5
	localparam int CFG_W     = 20;  // config data width, widest register
	localparam int CFG_BB_W  = 17;  // buffer_bytes register width
	localparam int MOD_STEP  = 4;   // remainder bits resolved per cycle
	localparam int MOD_CYC   = POS_W / MOD_STEP;
	localparam int MOD_CNT_W = $clog2(MOD_CYC + 1);
	localparam int Q_DEPTH   = 2;
	localparam int Q_PTR_W   = $clog2(Q_DEPTH);
	localparam int Q_CNT_W   = $clog2(Q_DEPTH + 1);

	// configuration register indexes
	localparam logic REG_BUFFER_BYTES = 1'b0;
	localparam logic REG_START_POS    = 1'b1;

	// request codes
	localparam logic REQ_WRITE = 1'b0;
	localparam logic REQ_ALIGN = 1'b1;

	// one classified request, handed from front to back
	typedef struct packed {
		logic [WIN_W-1:0]  window;
		logic [ADDR_W-1:0] addr;
		logic [NB_W-1:0]   nbytes;
		logic              byte_valid;
		logic              status;
	} job_t;

	// byte k of the window, counted from the top
	function automatic logic [7:0] win_byte(input logic [WIN_W-1:0] w,
	                                        input logic [NB_W-1:0] k);
		logic [7:0] b;
		case (k)
			3'd0:    b = w[39:32];
			3'd1:    b = w[31:24];
			3'd2:    b = w[23:16];
			3'd3:    b = w[15:8];
			3'd4:    b = w[7:0];
			default: b = 8'h00;
		endcase
		return b;
	endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/mbp_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mbp_front
// Accepts requests, resolves padding length, checks capacity, updates the
// write position and hands a byte window to the back end.
// ----------------------------------------------------------------------------
module mbp_front import mbp_pkg::*; #(
	parameter int MAX_BUFFER_BYTES = 65536,
	parameter int MAX_FIELD_BITS   = 32
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	output logic                  full,
	input  wire logic             req_type,
	input  wire logic [VAL_W-1:0] field_value,
	input  wire logic [CNT_W-1:0] bit_count,
	input  wire logic [CNT_W-1:0] align_multiple,
	input  wire logic             wr_en,
	input  wire logic             wr_index,
	input  wire logic [CFG_W-1:0] wr_data,
	output logic                  q_push,
	output job_t                  q_job,
	input  wire logic             q_full
);

	localparam int BB_W  = $clog2(MAX_BUFFER_BYTES + 1);
	localparam int CMP_W = (BB_W > CFG_BB_W) ? BB_W : CFG_BB_W;
	localparam int CAP_W = CMP_W + 3;
	localparam int SUM_W = CAP_W + 1;
	localparam logic [CMP_W-1:0] MAX_BB  = CMP_W'(MAX_BUFFER_BYTES);
	localparam logic [CAP_W-1:0] CAP_RST = {MAX_BB, 3'b000};
	localparam logic [CNT_W-1:0] MAXF    = CNT_W'(MAX_FIELD_BITS);

	logic             s1_valid_q;
	logic             s1_req_q;
	logic [VAL_W-1:0] s1_vj_q;     // value, left-justified and masked
	logic [CNT_W-1:0] s1_cnt_q;
	logic [CNT_W-1:0] s1_mul_q;

	logic [MOD_CNT_W-1:0] mod_left_q;
	logic [CNT_W-1:0]     mod_rem_q;
	logic [POS_W-1:0]     mod_pos_q;

	logic [POS_W-1:0] pos_q;
	logic [7:0]       partial_q;
	logic [CAP_W-1:0] cap_q;

	logic             accept;
	logic             exec;
	logic             write_ok;
	logic [CNT_W-1:0] rem_nx;
	logic [CNT_W:0]   rem_t;
	logic [CNT_W-1:0] n;
	logic [SUM_W-1:0] sum;
	logic             ovf;
	logic             nothing;
	logic [2:0]       bidx;
	logic [WIN_W-1:0] window;
	logic [NB_W-1:0]  nb;
	logic [POS_W-1:0] pos_inc;
	logic [POS_W-1:0] pos_d;
	logic [7:0]       partial_d;
	logic [CMP_W-1:0] wr_bb;
	logic [CMP_W-1:0] wr_bb_sat;
	logic [VAL_W-1:0] in_vj;

	// four restoring-remainder steps on the next position nibble
	always_comb begin
		rem_nx = mod_rem_q;
		rem_t  = '0;
		for (int j = 0; j < MOD_STEP; j++) begin
			rem_t = {rem_nx, mod_pos_q[POS_W-1-j]};
			if (rem_t >= {1'b0, s1_mul_q})
				rem_t = rem_t - {1'b0, s1_mul_q};
			rem_nx = rem_t[CNT_W-1:0];
		end
	end

	always_comb begin
		if (s1_req_q == REQ_WRITE)
			n = s1_cnt_q;
		else if (s1_mul_q == '0 || mod_rem_q == '0)
			n = '0;
		else
			n = s1_mul_q - mod_rem_q;
		sum     = SUM_W'(pos_q) + SUM_W'(n);
		ovf     = (n > MAXF) || ((n != '0) && (sum > SUM_W'(cap_q)));
		nothing = (n == '0);
		bidx    = pos_q[2:0];
		window  = {partial_q, {VAL_W{1'b0}}} | ({s1_vj_q, 8'h00} >> bidx);
		nb      = NB_W'((7'(bidx) + 7'(n) + 7'd7) >> 3);
		pos_inc = pos_q + POS_W'(n);
	end

	assign exec     = s1_valid_q && (mod_left_q == '0) && !q_full;
	assign write_ok = exec && !ovf && !nothing;
	assign full     = s1_valid_q && !exec;
	assign accept   = push && !full;
	assign q_push   = exec;

	always_comb begin
		if (ovf || nothing) begin
			q_job.window     = '0;
			q_job.addr       = '0;
			q_job.nbytes     = NB_W'(1);
			q_job.byte_valid = 1'b0;
			q_job.status     = ovf;
		end else begin
			q_job.window     = window;
			q_job.addr       = pos_q[ADDR_W+2:3];
			q_job.nbytes     = nb;
			q_job.byte_valid = 1'b1;
			q_job.status     = 1'b0;
		end
	end

	// next position and partial byte, config write has last word
	always_comb begin
		pos_d     = pos_q;
		partial_d = partial_q;
		if (write_ok) begin
			pos_d = pos_inc;
			if (pos_inc[2:0] == 3'b000)
				partial_d = 8'h00;
			else
				partial_d = win_byte(window, nb - NB_W'(1));
		end
		if (wr_en && wr_index == REG_START_POS) begin
			pos_d     = wr_data[POS_W-1:0];
			partial_d = 8'h00;
		end
	end

	always_comb begin
		wr_bb = CMP_W'(wr_data[CFG_BB_W-1:0]);
		if (wr_bb == '0)
			wr_bb_sat = CMP_W'(1);
		else if (wr_bb > MAX_BB)
			wr_bb_sat = MAX_BB;
		else
			wr_bb_sat = wr_bb;
	end

	assign in_vj = (req_type == REQ_WRITE) ?
	               (field_value << (CNT_W'(VAL_W) - bit_count)) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
			mod_left_q <= '0;
			pos_q      <= '0;
			partial_q  <= 8'h00;
			cap_q      <= CAP_RST;
		end else begin
			pos_q     <= pos_d;
			partial_q <= partial_d;
			if (wr_en && wr_index == REG_BUFFER_BYTES)
				cap_q <= {wr_bb_sat, 3'b000};
			if (accept) begin
				s1_valid_q <= 1'b1;
				mod_left_q <= (req_type == REQ_ALIGN && align_multiple != '0) ?
				              MOD_CNT_W'(MOD_CYC) : '0;
			end else begin
				if (exec)
					s1_valid_q <= 1'b0;
				if (s1_valid_q && mod_left_q != '0)
					mod_left_q <= mod_left_q - MOD_CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			s1_req_q  <= req_type;
			s1_vj_q   <= in_vj;
			s1_cnt_q  <= bit_count;
			s1_mul_q  <= align_multiple;
			mod_rem_q <= '0;
			mod_pos_q <= pos_d;
		end else if (s1_valid_q && mod_left_q != '0) begin
			mod_rem_q <= rem_nx;
			mod_pos_q <= mod_pos_q << MOD_STEP;
		end
	end

endmodule
`default_nettype wire

// ===== hw/rtl/mbp_fifo.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mbp_fifo
// Two-entry queue of jobs between the front and back ends.
// ----------------------------------------------------------------------------
module mbp_fifo import mbp_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic wr,
	input  wire job_t wr_job,
	output logic      q_full,
	input  wire logic rd,
	output job_t      rd_job,
	output logic      q_empty
);

	job_t               ent_q [Q_DEPTH];
	logic [Q_PTR_W-1:0] wr_ptr_q;
	logic [Q_PTR_W-1:0] rd_ptr_q;
	logic [Q_CNT_W-1:0] count_q;

	assign q_full  = (count_q == Q_CNT_W'(Q_DEPTH));
	assign q_empty = (count_q == '0);
	assign rd_job  = ent_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr)
				wr_ptr_q <= wr_ptr_q + Q_PTR_W'(1);
			if (rd)
				rd_ptr_q <= rd_ptr_q + Q_PTR_W'(1);
			if (wr && !rd)
				count_q <= count_q + Q_CNT_W'(1);
			else if (rd && !wr)
				count_q <= count_q - Q_CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (wr)
			ent_q[wr_ptr_q] <= wr_job;
	end

endmodule
`default_nettype wire

// ===== hw/rtl/mbp_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mbp_back
// Walks the bytes of the head job into the output register, one result
// per cycle while that register is empty or being popped.
// ----------------------------------------------------------------------------
module mbp_back import mbp_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire job_t              head,
	input  wire logic              q_empty,
	output logic                   q_pop,
	output logic                   empty,
	input  wire logic              pop,
	output logic [ADDR_W-1:0]      byte_address,
	output logic [7:0]             byte_value,
	output logic                   byte_valid,
	output logic                   status,
	output logic                   last
);

	logic [NB_W-1:0] k_q;
	logic            out_valid_q;
	logic            emit;
	logic            is_last;

	assign is_last = (k_q == head.nbytes - NB_W'(1));
	assign emit    = !q_empty && (!out_valid_q || pop);
	assign q_pop   = emit && is_last;
	assign empty   = !out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q         <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (emit)
				out_valid_q <= 1'b1;
			else if (pop)
				out_valid_q <= 1'b0;
			if (emit)
				k_q <= is_last ? '0 : k_q + NB_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			byte_address <= head.addr + ADDR_W'(k_q);
			byte_value   <= win_byte(head.window, k_q);
			byte_valid   <= head.byte_valid;
			status       <= head.status;
			last         <= is_last;
		end
	end

endmodule
`default_nettype wire

// ===== hw/rtl/msb_first_bit_packer.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// msb_first_bit_packer
// Packs variable-width fields MSB first into a byte buffer and reports every
// byte touched.
// ----------------------------------------------------------------------------
// A write request appends the low bit_count bits of field_value; an align
// request appends zeros up to the next multiple of align_multiple. Each
// request yields one result per byte it touches (address and contents, not
// yet written low bits zero) with last on the final one, or a single
// status-only result when there is nothing to append or the request would
// not fit (status = overflow, nothing written). Timing: the front end takes
// one write request per cycle while the two-entry job queue has room; an
// align request with a nonzero multiple first passes the remainder unit,
// which resolves four bits of the 20-bit position per cycle. The back end
// emits one result per cycle while its output register is free or popped,
// and that byte walk sets the sustained rate. Results sit in an output
// register; while a result waits for pop, new requests keep flowing until
// the job queue and the front stage are full.
// Configuration writes take effect at once and are meant for idle periods;
// writing start_bit_position moves the write position and clears the
// partial byte.
// ----------------------------------------------------------------------------
module msb_first_bit_packer import mbp_pkg::*; #(
	parameter int MAX_BUFFER_BYTES = 65536,
	parameter int MAX_FIELD_BITS   = 32
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	// request side
	input  wire logic              push,
	output logic                   full,
	input  wire logic              req_type,
	input  wire logic [VAL_W-1:0]  field_value,
	input  wire logic [CNT_W-1:0]  bit_count,
	input  wire logic [CNT_W-1:0]  align_multiple,
	// result side
	output logic                   empty,
	input  wire logic              pop,
	output logic [ADDR_W-1:0]      byte_address,
	output logic [7:0]             byte_value,
	output logic                   byte_valid,
	output logic                   status,
	output logic                   last,
	// configuration
	input  wire logic              wr_en,
	input  wire logic              wr_index,
	input  wire logic [CFG_W-1:0]  wr_data
);

	job_t q_in;
	job_t q_head;
	logic q_push;
	logic q_full;
	logic q_pop;
	logic q_empty;

	// front: classify, capacity check, position update
	mbp_front #(
		.MAX_BUFFER_BYTES(MAX_BUFFER_BYTES),
		.MAX_FIELD_BITS  (MAX_FIELD_BITS)
	) u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.push          (push),
		.full          (full),
		.req_type      (req_type),
		.field_value   (field_value),
		.bit_count     (bit_count),
		.align_multiple(align_multiple),
		.wr_en         (wr_en),
		.wr_index      (wr_index),
		.wr_data       (wr_data),
		.q_push        (q_push),
		.q_job         (q_in),
		.q_full        (q_full)
	);

	// decouples the front stage from the byte-by-byte walk in the back end
	mbp_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (q_push),
		.wr_job (q_in),
		.q_full (q_full),
		.rd     (q_pop),
		.rd_job (q_head),
		.q_empty(q_empty)
	);

	// back: one byte transfer per cycle while the output register is free or popped
	mbp_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.head        (q_head),
		.q_empty     (q_empty),
		.q_pop       (q_pop),
		.empty       (empty),
		.pop         (pop),
		.byte_address(byte_address),
		.byte_value  (byte_value),
		.byte_valid  (byte_valid),
		.status      (status),
		.last        (last)
	);

endmodule
`default_nettype wire

// ===== bench/tb_msb_first_bit_packer.sv =====
// ----------------------------------------------------------------------------
// tb_msb_first_bit_packer
// Self-checking bench for the MSB-first bit packer: field requests go in
// through a clocked driver, byte reports come out through a clocked monitor
// and are compared against a bit-accurate packing predictor.
// ----------------------------------------------------------------------------
// Flow: a directed pass over the corner cases (empty writes, full 32-bit
// fields, oversize counts, align to 0/1/odd/oversize multiples, tiny and
// saturated buffers, start positions near and past the end of the buffer),
// then random phases. Each phase reprograms the buffer size and start
// position while the block is idle. Both sides draw random idle gaps per
// transfer; some phases run without any gaps.
// ----------------------------------------------------------------------------
module tb_msb_first_bit_packer;
	import mbp_pkg::*;

	localparam int MAX_BUFFER_BYTES = 65536;
	localparam int MAX_FIELD_BITS   = 32;
	localparam int CYCLE_LIMIT      = 400000;
	localparam int RAND_PHASES      = 8;
	localparam int PHASE_ITEMS      = 50;
	localparam int TAIL_CYCLES      = 20;

	// one request as the driver presents it
	typedef struct packed {
		logic             kind;
		logic [VAL_W-1:0] value;
		logic [CNT_W-1:0] count;
		logic [CNT_W-1:0] multiple;
	} field_req_t;

	// one byte report (or status-only result)
	typedef struct packed {
		logic [ADDR_W-1:0] addr;
		logic [7:0]        value;
		logic              valid;
		logic              status;
		logic              last;
	} byte_rep_t;

	// clock, reset and DUT ports; every driven signal starts at a known value
	logic              clk            = 1'b0;
	logic              arst_n         = 1'b0;
	logic              push           = 1'b0;
	logic              full;
	logic              req_type       = REQ_WRITE;
	logic [VAL_W-1:0]  field_value    = '0;
	logic [CNT_W-1:0]  bit_count      = '0;
	logic [CNT_W-1:0]  align_multiple = '0;
	logic              empty;
	logic              pop            = 1'b0;
	logic [ADDR_W-1:0] byte_address;
	logic [7:0]        byte_value;
	logic              byte_valid;
	logic              status;
	logic              last;
	logic              wr_en          = 1'b0;
	logic              wr_index       = REG_BUFFER_BYTES;
	logic [CFG_W-1:0]  wr_data        = '0;

	// predictor copy of registers and packing state
	logic [CFG_BB_W-1:0] cfg_buf_bytes = 17'h10000;
	logic [POS_W-1:0]    pack_pos      = '0;
	logic [7:0]          pack_partial  = '0;

	field_req_t field_q[$];        // requests waiting to be driven
	byte_rep_t  byte_reports_q[$]; // predicted reports, oldest first
	field_req_t cur_req;

	int drv_gap      = -1;
	int mon_gap      = -1;
	bit idle_on      = 1'b1;
	int n_mismatch   = 0;
	int n_requests   = 0;
	int n_reports    = 0;
	int n_overflows  = 0;
	int n_phases     = 0;
	int cycle_count  = 0;

	msb_first_bit_packer i_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.push           (push),
		.full           (full),
		.req_type       (req_type),
		.field_value    (field_value),
		.bit_count      (bit_count),
		.align_multiple (align_multiple),
		.empty          (empty),
		.pop            (pop),
		.byte_address   (byte_address),
		.byte_value     (byte_value),
		.byte_valid     (byte_valid),
		.status         (status),
		.last           (last),
		.wr_en          (wr_en),
		.wr_index       (wr_index),
		.wr_data        (wr_data)
	);

	always #10 clk = ~clk;

	// hard stop in case the handshake hangs
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d reports still pending",
			         cycle_count, byte_reports_q.size());
			$display("tb_msb_first_bit_packer NOT OK");
			$finish;
		end
	end

	function automatic int draw_idle();
		return idle_on ? int'($urandom_range(0, 12)) : 0;
	endfunction

	// Packing predictor: computes the byte reports one request causes and
	// advances the bit position / partial byte.
	function automatic void pack_field(input field_req_t rq);
		logic [63:0] cap, pos, room, n, v, w, m;
		int          bidx, nb, sh;
		byte_rep_t   r;
		cap = 64'(cfg_buf_bytes);
		if (cap < 1) cap = 1;
		if (cap > MAX_BUFFER_BYTES) cap = MAX_BUFFER_BYTES;
		cap  = cap * 8;
		pos  = 64'(pack_pos);
		room = (pos < cap) ? cap - pos : 64'd0;
		if (rq.kind == REQ_WRITE) begin
			n = 64'(rq.count);
			v = 64'(rq.value);
		end else begin
			// pad to the next multiple; a zero multiple pads nothing
			m = 64'(rq.multiple);
			v = '0;
			n = (m == 0) ? 64'd0 : (m - (pos % m)) % m;
		end
		// oversize field or padding, or no room left: nothing is written
		if (n > MAX_FIELD_BITS || n > room) begin
			r = '{addr: '0, value: '0, valid: 1'b0, status: 1'b1, last: 1'b1};
			byte_reports_q.push_back(r);
			n_overflows++;
			return;
		end
		// nothing to append: one status-only report
		if (n == 0) begin
			r = '{addr: '0, value: '0, valid: 1'b0, status: 1'b0, last: 1'b1};
			byte_reports_q.push_back(r);
			return;
		end
		v    = v & ((64'd1 << n) - 64'd1);
		bidx = int'(pos[2:0]);
		sh   = 40 - bidx - int'(n);
		// 40-bit window, current byte on top
		w    = (64'(pack_partial) << 32) | (v << sh);
		nb   = (bidx + int'(n) + 7) / 8;
		for (int k = 0; k < nb; k++) begin
			r.addr   = ADDR_W'((pos >> 3) + 64'(k));
			r.value  = 8'(w >> (32 - 8 * k));
			r.valid  = 1'b1;
			r.status = 1'b0;
			r.last   = (k == nb - 1);
			byte_reports_q.push_back(r);
		end
		pos      = pos + n;
		pack_pos = POS_W'(pos);
		pack_partial = (pos[2:0] == 3'd0) ? 8'h00 : r.value;
	endfunction

	// Driver: holds a request until the transfer, draws a gap before each.
	always @(posedge clk or negedge arst_n) begin
		logic took;
		if (!arst_n) begin
			push    <= 1'b0;
			drv_gap = -1;
		end else begin
			took = push && !full;
			if (took) begin
				pack_field(cur_req);
				n_requests++;
			end
			if (!push || took) begin
				if (drv_gap < 0 && field_q.size() != 0)
					drv_gap = draw_idle();
				if (drv_gap > 0) begin
					drv_gap--;
					push <= 1'b0;
				end else if (drv_gap == 0) begin
					cur_req        = field_q.pop_front();
					req_type       <= cur_req.kind;
					field_value    <= cur_req.value;
					bit_count      <= cur_req.count;
					align_multiple <= cur_req.multiple;
					push           <= 1'b1;
					drv_gap        = -1;
				end else begin
					push <= 1'b0;
				end
			end
		end
	end

	// Monitor: checks every report transfer against the oldest prediction.
	always @(posedge clk or negedge arst_n) begin
		byte_rep_t got, want;
		if (!arst_n) begin
			pop     <= 1'b0;
			mon_gap = -1;
		end else begin
			if (pop && !empty) begin
				got = '{addr: byte_address, value: byte_value, valid: byte_valid,
				        status: status, last: last};
				n_reports++;
				if (byte_reports_q.size() == 0) begin
					if (n_mismatch < 10)
						$display("unexpected report addr=%h val=%h valid=%b st=%b last=%b",
						         got.addr, got.value, got.valid, got.status, got.last);
					n_mismatch++;
				end else begin
					want = byte_reports_q.pop_front();
					if (got !== want) begin
						if (n_mismatch < 10) begin
							$write("report %0d: exp addr=%h val=%h valid=%b st=%b last=%b, ",
							       n_reports, want.addr, want.value, want.valid,
							       want.status, want.last);
							$display("got addr=%h val=%h valid=%b st=%b last=%b",
							         got.addr, got.value, got.valid, got.status,
							         got.last);
						end
						n_mismatch++;
					end
				end
				mon_gap = draw_idle();
			end else if (mon_gap < 0) begin
				mon_gap = draw_idle();
			end
			if (mon_gap > 0) begin
				mon_gap--;
				pop <= 1'b0;
			end else begin
				pop <= 1'b1;
			end
		end
	end

	// wait until every queued request went in and every report came out
	task automatic wait_idle();
		while (field_q.size() != 0 || push || byte_reports_q.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_reg(input logic idx, input logic [CFG_W-1:0] data);
		@(posedge clk);
		wr_en    <= 1'b1;
		wr_index <= idx;
		wr_data  <= data;
		if (idx == REG_BUFFER_BYTES) begin
			cfg_buf_bytes = data[CFG_BB_W-1:0];
		end else begin
			pack_pos     = data;
			pack_partial = 8'h00;
		end
	endtask

	// reprogram both registers between phases
	task automatic set_buffer(input logic [CFG_W-1:0] bb, input logic [CFG_W-1:0] sp);
		wait_idle();
		write_reg(REG_BUFFER_BYTES, bb);
		write_reg(REG_START_POS, sp);
		@(posedge clk);
		wr_en <= 1'b0;
		n_phases++;
	endtask

	// unused fields of a request carry random noise
	task automatic add_write(input logic [VAL_W-1:0] v, input int c);
		field_req_t rq;
		rq.kind     = REQ_WRITE;
		rq.value    = v;
		rq.count    = CNT_W'(c);
		rq.multiple = CNT_W'($urandom);
		field_q.push_back(rq);
	endtask

	task automatic add_align(input int m);
		field_req_t rq;
		rq.kind     = REQ_ALIGN;
		rq.value    = $urandom;
		rq.count    = CNT_W'($urandom);
		rq.multiple = CNT_W'(m);
		field_q.push_back(rq);
	endtask

	task automatic add_random();
		int          sel;
		logic [31:0] v;
		sel = $urandom_range(0, 99);
		case ($urandom_range(0, 5))
			0:       v = 32'h0000_0000;
			1:       v = 32'hffff_ffff;
			default: v = $urandom;
		endcase
		if (sel < 6)
			add_write(v, $urandom_range(33, 63));           // oversize count
		else if (sel < 62)
			add_write(v, $urandom_range(0, 32));
		else if (sel < 66)
			add_align(0);
		else if (sel < 72)
			add_align($urandom_range(33, 63));              // padding may be too long
		else if (sel < 86)
			add_align(1 << $urandom_range(0, 5));
		else
			add_align($urandom_range(1, 32));
	endtask

	initial begin
		int bb, capb, sp;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: reset defaults (full buffer, start at bit 0)
		add_write(32'hffff_ffff, 0);      // nothing to append
		add_write(32'h0000_0001, 1);
		add_write(32'hffff_ffff, 32);     // five bytes touched
		add_write(32'h0000_0000, 32);
		add_write(32'h0000_00a5, 7);      // high value bits dropped
		add_align(8);
		add_align(8);                     // already aligned
		add_align(0);                     // zero multiple pads nothing
		add_write(32'h1234_5678, 33);     // count above field width
		add_write(32'hffff_ffff, 63);
		add_write(32'h0000_0005, 3);
		add_align(63);
		add_align(32);
		add_align(1);
		add_write(32'h7fff_ffff, 31);
		add_align(5);
		wait_idle();

		// one-byte buffer: fill it, then overflow
		set_buffer(20'd1, 20'd0);
		add_write(32'h0000_00ff, 8);
		add_write(32'h0000_0001, 1);
		add_write(32'h0000_0000, 0);
		add_align(8);
		// zero size saturates to one byte; unaligned start
		set_buffer(20'd0, 20'd3);
		add_write(32'h0000_001f, 5);
		add_write(32'h0000_0001, 1);
		// oversize buffer saturates; start far beyond the end
		set_buffer(20'h1ffff, 20'hfffff);
		add_write(32'h0000_0001, 1);
		add_write(32'h0000_0000, 0);
		add_align(4);
		// last nibble of a full buffer
		set_buffer(20'h10000, 20'd524284);
		add_write(32'h0000_000f, 4);
		add_write(32'h0000_0001, 1);
		add_align(3);

		// random phases with fresh buffer geometry each time
		for (int p = 0; p < RAND_PHASES; p++) begin
			case ($urandom_range(0, 5))
				0:       bb = $urandom_range(1, 16);
				1:       bb = 0;
				2:       bb = MAX_BUFFER_BYTES;
				3:       bb = $urandom_range(MAX_BUFFER_BYTES + 1, 131071);
				4:       bb = $urandom_range(1, MAX_BUFFER_BYTES);
				default: bb = $urandom_range(17, 64);
			endcase
			capb = (bb < 1) ? 8 : (bb > MAX_BUFFER_BYTES) ? MAX_BUFFER_BYTES * 8 : bb * 8;
			case ($urandom_range(0, 3))
				0:       sp = 0;
				1:       sp = $urandom_range(0, capb - 1);
				2:       sp = (capb > 300) ? capb - int'($urandom_range(0, 300)) : 0;
				default: sp = $urandom_range(0, 20'hfffff);
			endcase
			// junk in the unused top bits of the size write
			if ($urandom_range(0, 3) == 0)
				bb = bb | (int'($urandom_range(0, 7)) << CFG_BB_W);
			set_buffer(CFG_W'(bb), CFG_W'(sp));
			idle_on = ($urandom_range(0, 3) != 0);
			for (int i = 0; i < PHASE_ITEMS; i++)
				add_random();
		end

		wait_idle();
		repeat (TAIL_CYCLES) @(posedge clk);

		if (byte_reports_q.size() != 0) begin
			$display("%0d predicted reports never arrived", byte_reports_q.size());
			n_mismatch++;
		end
		$display("covered %0d requests in %0d phases, %0d reports checked, %0d overflows",
		         n_requests, n_phases + 1, n_reports, n_overflows);
		$display("mismatches: %0d", n_mismatch);
		if (n_mismatch == 0) begin
			$display("tb_msb_first_bit_packer OK");
		end else begin
			$display("tb_msb_first_bit_packer NOT OK");
		end
		$finish;
	end

endmodule

// ===== files.f =====
hw/rtl/mbp_pkg.sv
hw/rtl/mbp_front.sv
hw/rtl/mbp_fifo.sv
hw/rtl/mbp_back.sv
hw/rtl/msb_first_bit_packer.sv
bench/tb_msb_first_bit_packer.sv
